// File: rtl/core/terk_pkg.sv
// package: shared constants, tables and control structs for the top-k router
`default_nettype none
package terk_pkg;
	localparam int EXPERTS_DEF = 64;
	localparam int MAX_K       = 64;
	localparam int TOPK_W      = 7;
	localparam int LOGIT_W     = 16;
	localparam int ID_W        = 6;
	localparam int WEIGHT_W    = 16;
	localparam int SUM_W       = 23;
	localparam int ERR_W       = 2;
	localparam logic [TOPK_W-1:0] TOPK_RESET = 7'd2;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_K    = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

	// exp(-x) tables in Q16, the step-zero entries hold the full 65536
	function automatic logic [16:0] exp_int(input logic [3:0] i);
		logic [16:0] r;
		unique case (i)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd24109;
			4'd2:    r = 17'd8869;
			4'd3:    r = 17'd3263;
			4'd4:    r = 17'd1200;
			4'd5:    r = 17'd442;
			4'd6:    r = 17'd162;
			4'd7:    r = 17'd60;
			4'd8:    r = 17'd22;
			4'd9:    r = 17'd8;
			4'd10:   r = 17'd3;
			4'd11:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic logic [16:0] exp_hi(input logic [3:0] h);
		logic [16:0] r;
		unique case (h)
			4'd0:  r = 17'd65536; 4'd1:  r = 17'd61565;
			4'd2:  r = 17'd57835; 4'd3:  r = 17'd54331;
			4'd4:  r = 17'd51039; 4'd5:  r = 17'd47947;
			4'd6:  r = 17'd45042; 4'd7:  r = 17'd42313;
			4'd8:  r = 17'd39750; 4'd9:  r = 17'd37341;
			4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
			4'd12: r = 17'd30957; 4'd13: r = 17'd29081;
			4'd14: r = 17'd27319; default: r = 17'd25664;
		endcase
		return r;
	endfunction

	function automatic logic [16:0] exp_lo(input logic [3:0] l);
		logic [16:0] r;
		unique case (l)
			4'd0:  r = 17'd65536; 4'd1:  r = 17'd65280;
			4'd2:  r = 17'd65026; 4'd3:  r = 17'd64772;
			4'd4:  r = 17'd64520; 4'd5:  r = 17'd64268;
			4'd6:  r = 17'd64018; 4'd7:  r = 17'd63768;
			4'd8:  r = 17'd63520; 4'd9:  r = 17'd63272;
			4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
			4'd12: r = 17'd62535; 4'd13: r = 17'd62291;
			4'd14: r = 17'd62048; default: r = 17'd61806;
		endcase
		return r;
	endfunction

	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_SCAN_INIT, OP_SCAN, OP_PICK, OP_EXP_INIT, OP_EXP,
		OP_DIV_INIT, OP_DIV, OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} terk_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic exp_done;
		logic div_done;
		logic pick_last;
		logic overflow;
		logic bad_k;
	} terk_sts_t;
endpackage
`default_nettype wire

// File: rtl/core/terk_if.sv
// valid/ready channel interfaces for the router
`default_nettype none
interface terk_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] logit;
	logic               last;
	modport source (output valid, logit, last, input ready);
	modport sink   (input valid, logit, last, output ready);
endinterface

interface terk_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  expert_id;
	logic [15:0] weight;
	logic        end_of_run;
	logic [1:0]  error;
	modport source (output valid, expert_id, weight, end_of_run, error, input ready);
	modport sink   (input valid, expert_id, weight, end_of_run, error, output ready);
endinterface

interface terk_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/topk_expert_router_softmax.sv
// top level of the top-k expert router with fixed-point softmax
//  channel | dir | word
//  in_ch   | in  | logit (s16 Q8.8), last
//  out_ch  | out | expert_id, weight (u16 Q0.16), end_of_run, error
//  cfg_ch  | in  | top_k (u7)
// one logit word per cycle while loading, then a check state after last
// after last and a passed check: k scans over the n stored logits, then the exp of every pick,
// then the bit-serial divider for each pick in turn, one result each
// reset clears count, flags and state; stores are undefined until written
// a stalled result holds the divider until taken; input and config wait
// until the final result of the token has left
`default_nettype none
module topk_expert_router_softmax import terk_pkg::*; #(
	parameter int EXPERTS = EXPERTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	terk_in_if.sink    in_ch,
	terk_out_if.source out_ch,
	terk_cfg_if.sink   cfg_ch
);
	terk_cmd_t         cmd;
	terk_sts_t         sts;
	logic [TOPK_W-1:0] top_k_q;
	logic              end_w;
	logic [ERR_W-1:0]  err_w;
	logic [ID_W-1:0]   id_w;
	logic [WEIGHT_W-1:0] wt_w;

	// configuration register, written only while idle or loading (ready follows the input ready)
	assign cfg_ch.ready = in_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) top_k_q <= TOPK_RESET;
		else if (cfg_ch.valid && cfg_ch.ready) top_k_q <= cfg_ch.data;
	end

	terk_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_ready(out_ch.ready), .sts, .cmd,
		.out_valid(out_ch.valid), .out_end(end_w), .out_err(err_w)
	);

	terk_datapath #(.EXPERTS(EXPERTS)) u_dp (
		.clk, .arst_n, .cmd, .in_logit(in_ch.logit), .top_k(top_k_q), .sts,
		.res_id(id_w), .res_weight(wt_w)
	);

	// error words carry zero id and weight
	assign out_ch.error      = err_w;
	assign out_ch.end_of_run = end_w;
	assign out_ch.expert_id  = (err_w == ERR_NONE) ? id_w : '0;
	assign out_ch.weight     = (err_w == ERR_NONE) ? wt_w : '0;
endmodule
`default_nettype wire

// File: rtl/core/terk_datapath.sv
// datapath: logit store, selection scan, exp and normaliser, divider
`default_nettype none
module terk_datapath import terk_pkg::*; #(
	parameter int EXPERTS = EXPERTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire terk_cmd_t           cmd,
	input  wire logic signed [15:0]  in_logit,
	input  wire logic [TOPK_W-1:0]   top_k,
	output terk_sts_t                sts,
	output logic [ID_W-1:0]          res_id,
	output logic [WEIGHT_W-1:0]      res_weight
);
	localparam int IW = (EXPERTS > 1) ? $clog2(EXPERTS) : 1;
	localparam int CW = $clog2(EXPERTS + 1);
	localparam int KW = $clog2(MAX_K);

	logic signed [15:0] store_q [EXPERTS];
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [IW-1:0]      sel_q [MAX_K];
	logic signed [15:0] selv_q [MAX_K];
	logic [15:0]        expv_q [MAX_K];
	logic [SUM_W-1:0]   sum_q;

	logic [CW-1:0]      j_q;
	logic [KW:0]        s_q;
	logic               found_q;
	logic [IW-1:0]      best_q;
	logic signed [15:0] bestv_q;
	logic signed [15:0] maxv_q;
	logic signed [15:0] rd_q;
	logic [IW-1:0]      rj_q;
	logic               rv_q;
	logic signed [15:0] prevv_q;
	logic [IW-1:0]      previ_q;
	logic [1:0]         ph_q;

	// exp pipeline regs
	logic [33:0] p1_q;
	logic [33:0] prod_q;
	logic [3:0]  lo_q;
	logic        zero_q;

	// divider
	logic [39:0]   rem_q;
	logic [16:0]   quo_q;
	logic [5:0]    bit_q;
	logic [15:0]   evr_q;
	logic [IW-1:0] id_q;

	logic          eligible;
	logic [16:0]   dd;
	logic [16:0]   v1;
	logic [16:0]   r2;
	logic [15:0]   ev_w;
	logic [39:0]   dsh;

	// a candidate must rank below the previous pick (value down, index up)
	assign eligible = (s_q == '0) || (rd_q < prevv_q) ||
		((rd_q == prevv_q) && (rj_q > previ_q));

	always_comb begin
		sts.scan_done = (j_q >= count_q) && !rv_q;
		sts.exp_done  = (s_q >= (KW+1)'(top_k));
		sts.div_done  = (bit_q == 6'd0) && (ph_q == 2'd2);
		sts.pick_last = (s_q + 1'b1 == (KW+1)'(top_k));
		sts.overflow  = ovf_q;
		sts.bad_k     = (top_k == '0) || (32'(top_k) > 32'(count_q))
			|| (top_k > TOPK_W'(MAX_K));
	end

	// exp stages: int * hi, then * lo, each rounded
	assign dd   = 17'(maxv_q) - 17'(rd_q);
	assign v1   = 17'((p1_q + 34'd32768) >> 16);
	assign r2   = 17'((prod_q + 34'd32768) >> 16);
	assign ev_w = zero_q ? 16'd0 : ((r2 > 17'd65535) ? 16'hFFFF : r2[15:0]);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && count_q < CW'(EXPERTS))
			store_q[count_q[IW-1:0]] <= in_logit;
		if (cmd.op == OP_PICK) begin
			sel_q[s_q[KW-1:0]]  <= best_q;
			selv_q[s_q[KW-1:0]] <= bestv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sum_q   <= '0;
			j_q <= '0; s_q <= '0; found_q <= 1'b0; ph_q <= '0;
			rv_q <= 1'b0;
			bit_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (count_q < CW'(EXPERTS)) count_q <= count_q + 1'b1;
					else ovf_q <= 1'b1;
				end
				OP_CLEAR: begin
					count_q <= '0; ovf_q <= 1'b0; s_q <= '0; ph_q <= '0;
				end
				OP_SCAN_INIT: begin
					j_q <= '0; found_q <= 1'b0; rv_q <= 1'b0;
				end
				OP_SCAN: begin
					// registered store read, compared in the next cycle
					if (j_q < count_q) begin
						rd_q <= store_q[j_q[IW-1:0]];
						rj_q <= j_q[IW-1:0];
						rv_q <= 1'b1;
						j_q  <= j_q + 1'b1;
					end else
						rv_q <= 1'b0;
					if (rv_q && eligible && (!found_q || rd_q > bestv_q)) begin
						best_q <= rj_q; bestv_q <= rd_q; found_q <= 1'b1;
					end
				end
				OP_PICK: begin
					prevv_q <= bestv_q;
					previ_q <= best_q;
					if (s_q == '0) maxv_q <= bestv_q;
					s_q <= s_q + 1'b1;
				end
				OP_EXP_INIT: begin
					s_q <= '0; sum_q <= '0; ph_q <= '0;
				end
				OP_EXP: begin
					if (sts.exp_done) begin
						s_q <= '0; ph_q <= 2'd0;
					end else begin
						unique case (ph_q)
							2'd0: begin
								rd_q <= selv_q[s_q[KW-1:0]];
								ph_q <= 2'd1;
							end
							2'd1: begin
								zero_q <= dd[15:8] >= 8'd12;
								lo_q   <= dd[3:0];
								p1_q   <= 34'(exp_int(dd[11:8])) * 34'(exp_hi(dd[7:4]));
								ph_q   <= 2'd2;
							end
							2'd2: begin
								prod_q <= 34'(v1) * 34'(exp_lo(lo_q));
								ph_q   <= 2'd3;
							end
							default: begin
								expv_q[s_q[KW-1:0]] <= ev_w;
								sum_q <= sum_q + SUM_W'(ev_w);
								s_q <= s_q + 1'b1;
								ph_q <= 2'd0;
							end
						endcase
					end
				end
				OP_DIV_INIT: begin
					evr_q <= expv_q[s_q[KW-1:0]];
					id_q  <= sel_q[s_q[KW-1:0]];
					quo_q <= '0; bit_q <= 6'd17; ph_q <= 2'd3;
				end
				OP_DIV: begin
					if (ph_q == 2'd3) begin
						rem_q <= {8'd0, evr_q, 16'd0} + 40'(sum_q >> 1);
						ph_q  <= 2'd1;
					end else if (bit_q != 6'd0) begin
						if (rem_q >= dsh) begin
							rem_q <= rem_q - dsh;
							quo_q <= {quo_q[15:0], 1'b1};
						end else
							quo_q <= {quo_q[15:0], 1'b0};
						bit_q <= bit_q - 1'b1;
					end else begin
						ph_q <= 2'd2;
					end
				end
				OP_IDLE: begin
					if (ph_q == 2'd2) begin
						s_q <= s_q + 1'b1; ph_q <= 2'd0;
					end
				end
				default: ;
			endcase
		end
	end

	assign dsh = 40'(sum_q) << (bit_q - 6'd1);

	always_comb begin
		res_id = ID_W'(id_q);
		if (sum_q == '0) res_weight = '0;
		else res_weight = quo_q[16] ? 16'hFFFF : quo_q[15:0];
	end
endmodule
`default_nettype wire

// File: rtl/core/terk_ctrl.sv
// controller: sequences load, selection, exp sum and per-pick division
`default_nettype none
module terk_ctrl import terk_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	terk_in_if.sink        in_ch,
	input  wire logic      out_ready,
	input  wire terk_sts_t sts,
	output terk_cmd_t      cmd,
	output logic           out_valid,
	output logic           out_end,
	output logic [1:0]     out_err
);
	typedef enum logic [3:0] {
		S_LOAD, S_CHECK, S_SCAN_INIT, S_SCAN, S_PICK, S_EXP_INIT, S_EXP,
		S_DIV_INIT, S_DIV, S_EMIT, S_ERR
	} state_t;

	state_t state_q;
	logic   last_pick_q;

	assign in_ch.ready = (state_q == S_LOAD);
	assign out_valid   = (state_q == S_EMIT) || (state_q == S_ERR);
	assign out_end     = (state_q == S_ERR) ? 1'b1 : last_pick_q;

	always_comb begin
		unique case (state_q)
			S_LOAD:      cmd.op = (in_ch.valid) ? OP_LOAD : OP_IDLE;
			S_SCAN_INIT: cmd.op = OP_SCAN_INIT;
			S_SCAN:      cmd.op = sts.scan_done ? OP_PICK : OP_SCAN;
			S_EXP_INIT:  cmd.op = OP_EXP_INIT;
			S_EXP:       cmd.op = OP_EXP;
			S_DIV_INIT:  cmd.op = OP_DIV_INIT;
			S_DIV:       cmd.op = OP_DIV;
			S_EMIT:      cmd.op = out_ready ? OP_IDLE : OP_DIV;
			S_ERR:       cmd.op = OP_IDLE;
			S_CHECK:     cmd.op = OP_IDLE;
			default:     cmd.op = OP_IDLE;
		endcase
		if (state_q == S_CHECK && (sts.overflow || sts.bad_k)) cmd.op = OP_IDLE;
		if ((state_q == S_ERR && out_ready) ||
			(state_q == S_EMIT && out_ready && last_pick_q)) cmd.op = OP_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; out_err <= ERR_NONE;
			last_pick_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: if (in_ch.valid && in_ch.last) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.overflow) begin
						out_err <= ERR_OVERFLOW; state_q <= S_ERR;
					end else if (sts.bad_k) begin
						out_err <= ERR_BAD_K; state_q <= S_ERR;
					end else begin
						out_err <= ERR_NONE; state_q <= S_SCAN_INIT;
					end
				end
				S_SCAN_INIT: state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= sts.pick_last ? S_EXP_INIT : S_SCAN_INIT;
				S_PICK: state_q <= S_SCAN_INIT;
				S_EXP_INIT: state_q <= S_EXP;
				S_EXP: if (sts.exp_done) state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					state_q <= S_DIV; last_pick_q <= 1'b0;
				end
				S_DIV: if (sts.div_done) begin
					state_q <= S_EMIT; last_pick_q <= sts.pick_last;
				end
				S_EMIT: if (out_ready)
					state_q <= last_pick_q ? S_LOAD : S_DIV_INIT;
				S_ERR: if (out_ready) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/topk_expert_router_softmax_tb.sv
// testbench: top-k expert router checked against an in-bench softmax predictor
`timescale 1ns / 1ps
module topk_expert_router_softmax_tb;
	import terk_pkg::*;

	typedef struct packed {
		logic signed [15:0] logit;
		logic               last;
	} logit_word_t;

	typedef struct packed {
		logic [5:0]  expert_id;
		logic [15:0] weight;
		logic        end_of_run;
		logic [1:0]  error;
	} route_word_t;

	localparam int NEXP      = 64;
	localparam int IDLE_WAIT = 3000;
	localparam int STALL_MAX = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	terk_in_if  in_ch ();
	terk_out_if out_ch ();
	terk_cfg_if cfg_ch ();

	topk_expert_router_softmax uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// exp(-x) tables in Q16, the step-zero entries hold the full 65536
	localparam int unsigned EI [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
		22, 8, 3, 1};
	localparam int unsigned EH [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
		42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	localparam int unsigned EL [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
		63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

	// predictor state
	logic [6:0]         k_sel = TOPK_RESET;
	logic signed [15:0] scores [NEXP];
	int unsigned        n_loaded = 0;
	bit                 dropped = 0;

	logit_word_t pending_logits [$];
	route_word_t expected_routes [$];
	int          fails = 0;
	bit          stim_done = 0;
	bit          sink_hold = 0;

	function automatic int unsigned neg_exp(input int unsigned d);
		longint unsigned v;
		if ((d >> 8) >= 12)
			return 0;
		v = EI[d >> 8];
		v = (v * EH[(d >> 4) & 15] + 32768) >> 16;
		v = (v * EL[d & 15] + 32768) >> 16;
		return v > 65535 ? 65535 : int'(v);
	endfunction

	task automatic push_error(input logic [1:0] code);
		route_word_t r;
		r.expert_id = '0;
		r.weight = '0;
		r.end_of_run = 1'b1;
		r.error = code;
		expected_routes.push_back(r);
	endtask

	// keep each accepted logit; route the token once its last logit is accepted
	task automatic predict_route(input logit_word_t w);
		bit              taken [NEXP];
		int unsigned     picks [NEXP];
		int unsigned     ev [NEXP];
		int unsigned     n, best, total;
		longint unsigned wt;
		bit              found;
		route_word_t     r;
		if (n_loaded < NEXP) begin
			scores[n_loaded] = w.logit;
			n_loaded++;
		end else begin
			dropped = 1;
		end
		if (!w.last)
			return;
		n = n_loaded;
		n_loaded = 0;
		if (dropped) begin
			dropped = 0;
			push_error(ERR_OVERFLOW);
			return;
		end
		if (k_sel == 0 || k_sel > n || k_sel > MAX_K) begin
			push_error(ERR_BAD_K);
			return;
		end
		foreach (taken[i]) taken[i] = 0;
		for (int s = 0; s < k_sel; s++) begin
			found = 0;
			best = 0;
			for (int j = 0; j < n; j++)
				if (!taken[j] && (!found || scores[j] > scores[best])) begin
					best = j;
					found = 1;
				end
			taken[best] = 1;
			picks[s] = best;
		end
		total = 0;
		for (int s = 0; s < k_sel; s++) begin
			ev[s] = neg_exp(int'(scores[picks[0]]) - int'(scores[picks[s]]));
			total += ev[s];
		end
		for (int s = 0; s < k_sel; s++) begin
			wt = total == 0 ? 0 : ((longint'(ev[s]) << 16) + (total >> 1)) / total;
			r.expert_id = picks[s][5:0];
			r.weight = wt > 65535 ? 16'hFFFF : wt[15:0];
			r.end_of_run = (s + 1 == k_sel);
			r.error = ERR_NONE;
			expected_routes.push_back(r);
		end
	endtask

	task automatic report(input string what, input route_word_t got, input route_word_t want);
		fails++;
		$display("mismatch %s: got id %0d w %0d eor %0b err %0d, want id %0d w %0d eor %0b err %0d",
			what, got.expert_id, got.weight, got.end_of_run, got.error,
			want.expert_id, want.weight, want.end_of_run, want.error);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver: offers queued logit words with random gaps
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.logit <= '0;
			in_ch.last  <= 1'b0;
			src_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_route('{logit: in_ch.logit, last: in_ch.last});
				void'(pending_logits.pop_front());
				src_gap = gap_len();
			end
			if (in_ch.valid && !in_ch.ready) begin
				// hold the word on offer
			end else if (src_gap > 0 || pending_logits.size() == 0) begin
				if (src_gap > 0) src_gap--;
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.logit <= pending_logits[0].logit;
				in_ch.last  <= pending_logits[0].last;
			end
		end
	end

	// monitor: compares each result word against the oldest expectation
	route_word_t seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen = '{out_ch.expert_id, out_ch.weight, out_ch.end_of_run, out_ch.error};
				if (expected_routes.size() == 0)
					report("unexpected", seen, '0);
				else if (seen !== expected_routes[0]) begin
					report("field", seen, expected_routes[0]);
					void'(expected_routes.pop_front());
				end else
					void'(expected_routes.pop_front());
			end
			out_ch.ready <= sink_hold ? 1'b0 : (gap_len() == 0 || $urandom_range(0, 1));
		end
	end

	// watchdog on cycles with no accepted word at all, outside a receiver hold
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || sink_hold)
			quiet = 0;
		else if (arst_n && !stim_done)
			quiet++;
		if (quiet > STALL_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_token(input int n, input bit wide);
		logit_word_t w;
		for (int i = 0; i < n; i++) begin
			if (wide)
				w.logit = 16'($urandom());
			else
				w.logit = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
			w.last = (i == n - 1);
			pending_logits.push_back(w);
		end
	endtask

	task automatic add_fixed(input logic signed [15:0] v, input bit last);
		pending_logits.push_back('{logit: v, last: last});
	endtask

	task automatic drain();
		while (pending_logits.size() != 0 || expected_routes.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_top_k(input logic [6:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		k_sel = v;
		cfg_ch.valid <= 1'b0;
	endtask

	logic [6:0]  k_plan [7] = '{7'd1, 7'd3, 7'd8, 7'd64, 7'd0, 7'd127, 7'd4};

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset top_k of two
		add_fixed(16'sh7FFF, 0); add_fixed(-16'sh8000, 0); add_fixed(16'sh7FFF, 1);
		add_fixed(16'sh0100, 0); add_fixed(16'sh0000, 1);   // one unit apart
		add_fixed(16'sh0005, 1);                            // top_k above count
		add_fixed(-16'sh8000, 0); add_fixed(-16'sh8000, 1); // equal logits
		add_fixed(16'sh0C00, 0); add_fixed(16'sh0000, 1);   // exp underflows
		add_fixed(16'sh0BFF, 0); add_fixed(16'sh0000, 0); add_fixed(16'sh0ABC, 1);
		drain();
		// overflow: 65 logits in one token, then normal again
		add_token(65, 1);
		add_token(3, 1);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			set_top_k(k_plan[ph]);
			if (k_plan[ph] == 7'd64) begin
				add_token(64, 0);
				add_token(63, 0);
			end else begin
				for (int t = 0; t < 5; t++) begin
					int n;
					n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) :
						$urandom_range((k_plan[ph] > 7'd1 && k_plan[ph] <= 7'd12) ?
							int'(k_plan[ph]) : 1, 12);
					add_token(n, $urandom_range(0, 1));
				end
			end
			if (ph == 2) begin
				// long receiver hold-off while words keep coming
				fork
					begin
						sink_hold = 1;
						repeat (400) @(posedge clk);
						sink_hold = 0;
					end
				join_none
			end
			drain();
		end
		stim_done = 1;
		if (fails == 0 && expected_routes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: topk_expert_router_softmax.f
rtl/core/terk_pkg.sv
rtl/core/terk_if.sv
rtl/core/terk_datapath.sv
rtl/core/terk_ctrl.sv
rtl/core/topk_expert_router_softmax.sv
tb/sv/topk_expert_router_softmax_tb.sv
